// File: hw/rtl/ssps_pkg.sv
// ----------------------------------------------------------------------------
// ssps_pkg
// Shared types and constants for the subarray target-sum detector.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ssps_pkg;

  // Default capacity of the prefix store.
  localparam int MAX_LEN_DEF = 1024;

  // Field widths.
  localparam int VALUE_W  = 16;
  localparam int TARGET_W = 26;
  localparam int SUM_W    = 27;
  localparam int IN_DW    = 16;
  localparam int OUT_DW   = 8;

  // Controller states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_FINISH
  } ssps_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;   // take the input request, update sum and store
    logic scan_rd;  // read the next stored prefix
    logic finish;   // close the item, emit a result if it was last
  } ssps_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic count_zero;  // store was empty when the item arrived
    logic scan_end;    // current read is the last one of the scan
    logic last_pend;   // current item closes its sequence
    logic out_free;    // output register can take a result
  } ssps_status_t;

endpackage

// File: hw/rtl/ssps_ram.sv
// ----------------------------------------------------------------------------
// ssps_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ssps_ram #(
  parameter int WIDTH = 27,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// File: hw/rtl/ssps_ctrl.sv
// ----------------------------------------------------------------------------
// ssps_ctrl
// Sequencer: accepts one request, scans a non-empty store, then closes the item.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ssps_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  ssps_pkg::ssps_status_t status,
  output ssps_pkg::ssps_cmd_t    cmd
);

  import ssps_pkg::*;

  ssps_state_t state;
  ssps_state_t state_next;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and commands.
  always_comb begin
    state_next  = state;
    cmd         = '0;
    s_tready    = 1'b0;
    case (state)
      ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          cmd.accept = 1'b1;
          state_next = status.count_zero ? ST_FINISH : ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd.scan_rd = 1'b1;
        if (status.scan_end) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        // The last read data is compared in this cycle.
        state_next = ST_FINISH;
      end
      ST_FINISH: begin
        if (!status.last_pend || status.out_free) begin
          cmd.finish = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Assertions.
  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.accept |=> (state == ST_SCAN || state == ST_FINISH))
    else $error("accepted request did not start processing");

  a_drain_to_finish: assert property (@(posedge clk) disable iff (rst)
    state == ST_DRAIN |=> state == ST_FINISH)
    else $error("drain cycle not followed by finish");

  a_ready_in_idle: assert property (@(posedge clk) disable iff (rst)
    s_tready |-> state == ST_IDLE)
    else $error("input ready outside idle");

endmodule

// File: hw/rtl/ssps_dp.sv
// ----------------------------------------------------------------------------
// ssps_dp
// Datapath: prefix sum, difference, prefix store, comparator, result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ssps_dp #(
  parameter int MAX_LEN = ssps_pkg::MAX_LEN_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_we,
  input  logic [ssps_pkg::TARGET_W-1:0]      cfg_wdata,
  input  logic [ssps_pkg::VALUE_W-1:0]       value,
  input  logic                               last,
  input  ssps_pkg::ssps_cmd_t                cmd,
  output ssps_pkg::ssps_status_t             status,
  output logic                               m_tvalid,
  input  logic                               m_tready,
  output logic [ssps_pkg::OUT_DW-1:0]        m_tdata
);

  import ssps_pkg::*;

  localparam int ADDR_W = $clog2(MAX_LEN);
  localparam int CNT_W  = $clog2(MAX_LEN + 1);
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_LEN);

  logic [TARGET_W-1:0] target_sum;
  logic [SUM_W-1:0]    running_sum;
  logic [SUM_W-1:0]    running_sum_next;
  logic [SUM_W-1:0]    diff;
  logic [SUM_W-1:0]    diff_next;
  logic [CNT_W-1:0]    count;
  logic [CNT_W-1:0]    limit;
  logic [CNT_W-1:0]    ptr;
  logic                found_flag;
  logic                overflow_flag;
  logic                last_pend;
  logic                cmp_valid;
  logic                found_out;
  logic                too_long_out;
  logic                store_wr;
  logic [SUM_W-1:0]    rd_data;
  logic                hit;

  // New prefix sum and its difference to the target, both mod 2^SUM_W.
  assign running_sum_next = running_sum
                          + {{(SUM_W - VALUE_W){value[VALUE_W-1]}}, value};
  assign diff_next = running_sum_next
                   - {{(SUM_W - TARGET_W){target_sum[TARGET_W-1]}}, target_sum};

  assign store_wr = cmd.accept && (count != CNT_MAX);
  assign hit      = cmp_valid && (rd_data == diff);

  // Prefix store.
  ssps_ram #(
    .WIDTH (SUM_W),
    .DEPTH (MAX_LEN)
  ) u_store (
    .clk     (clk),
    .wr_en   (store_wr),
    .wr_addr (count[ADDR_W-1:0]),
    .wr_data (running_sum_next),
    .rd_en   (cmd.scan_rd),
    .rd_addr (ptr[ADDR_W-1:0]),
    .rd_data (rd_data)
  );

  // Target register.
  always_ff @(posedge clk) begin
    if (rst) begin
      target_sum <= '0;
    end else if (cfg_we) begin
      target_sum <= cfg_wdata;
    end
  end

  // Sequence state: running sum, fill count, sticky flags.
  always_ff @(posedge clk) begin
    if (rst) begin
      running_sum   <= '0;
      count         <= '0;
      found_flag    <= 1'b0;
      overflow_flag <= 1'b0;
      cmp_valid     <= 1'b0;
    end else begin
      cmp_valid <= cmd.scan_rd;
      if (cmd.accept) begin
        running_sum <= running_sum_next;
        if (diff_next == '0) begin
          found_flag <= 1'b1;
        end
        if (count != CNT_MAX) begin
          count <= count + CNT_W'(1);
        end else begin
          overflow_flag <= 1'b1;
        end
      end else if (hit) begin
        found_flag <= 1'b1;
      end else if (cmd.finish && last_pend) begin
        running_sum   <= '0;
        count         <= '0;
        found_flag    <= 1'b0;
        overflow_flag <= 1'b0;
      end
    end
  end

  // Per-item working registers.
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      diff      <= diff_next;
      limit     <= count;
      ptr       <= '0;
      last_pend <= last;
    end else if (cmd.scan_rd) begin
      ptr <= ptr + CNT_W'(1);
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.finish && last_pend) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish && last_pend) begin
      found_out    <= found_flag;
      too_long_out <= overflow_flag;
    end
  end

  assign m_tdata = {{(OUT_DW - 2){1'b0}}, too_long_out, found_out};

  // Status to the controller.
  always_comb begin
    status.count_zero = (count == '0);
    status.scan_end   = (ptr == limit - CNT_W'(1));
    status.last_pend  = last_pend;
    status.out_free   = !m_tvalid || m_tready;
  end

  // Assertions.
  a_scan_in_range: assert property (@(posedge clk) disable iff (rst)
    cmd.scan_rd |-> ptr < limit)
    else $error("store read beyond written entries");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_MAX)
    else $error("fill count exceeds store depth");

  a_result_loaded: assert property (@(posedge clk) disable iff (rst)
    cmd.finish && last_pend |=> m_tvalid && count == '0)
    else $error("closing item did not produce a result and clear state");

endmodule

// File: hw/rtl/subarray_sum_prefix_set_detect_top.sv
// Sequence: an item is accepted in IDLE, SCAN reads the N stored prefixes, DRAIN
// compares the last read and FINISH closes the item; N (1 to MAX_LEN) is the number
// of stored prefixes; with N = 0 the item goes to FINISH directly. The next item is
// taken only after FINISH, as one store read port and one comparator scan. A closing
// item also waits while the previous result is still unread on the master side.
// Reset (rst, synchronous) clears target, sums, counts and flags; store is not cleared.
// ----------------------------------------------------------------------------
// subarray_sum_prefix_set_detect_top
// Detects a contiguous run of inputs summing to a target via prefix sums.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module subarray_sum_prefix_set_detect_top #(
  parameter int MAX_LEN = ssps_pkg::MAX_LEN_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  // Configuration: target_sum.
  input  logic                          cfg_we,
  input  logic [ssps_pkg::TARGET_W-1:0] cfg_wdata,
  // Input stream.
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [ssps_pkg::IN_DW-1:0]    s_tdata,   // [15:0] value
  input  logic                          s_tlast,
  // Result stream.
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [ssps_pkg::OUT_DW-1:0]   m_tdata    // [0] found, [1] too_long, rest zero
);

  import ssps_pkg::*;

  ssps_cmd_t    cmd;
  ssps_status_t status;

  ssps_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .status   (status),
    .cmd      (cmd)
  );

  ssps_dp #(
    .MAX_LEN (MAX_LEN)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .value     (s_tdata[VALUE_W-1:0]),
    .last      (s_tlast),
    .cmd       (cmd),
    .status    (status),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

endmodule

// File: verif/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the subarray target-sum detector. A scoreboard
// tracks the running prefix sum and the stored prefixes of every accepted
// request and predicts found and too_long for each closing request. Stimulus
// covers directed edge cases, random sequences under several targets and
// stall patterns, and a long receiver hold-off.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

// Scoreboard: predicts the result of each sequence and checks what comes out.
class prefix_match_board;

  typedef struct {
    bit found;
    bit too_long;
  } seq_flags_t;

  logic [ssps_pkg::TARGET_W-1:0] target;
  logic [ssps_pkg::SUM_W-1:0]    run_sum;
  logic [ssps_pkg::SUM_W-1:0]    seen_sums[$];
  bit                            hit;
  bit                            spill;
  seq_flags_t                    expected_flags[$];
  int                            errors;

  function new();
    target  = '0;
    run_sum = '0;
    hit     = 1'b0;
    spill   = 1'b0;
    errors  = 0;
  endfunction

  function void set_target(logic [ssps_pkg::TARGET_W-1:0] t);
    target = t;
  endfunction

  function int pending();
    return expected_flags.size();
  endfunction

  function int fail_count();
    return errors + expected_flags.size();
  endfunction

  // Advance the prefix sum and look for an earlier prefix at distance target.
  function void note_request(logic [15:0] value, bit last);
    logic [ssps_pkg::SUM_W-1:0] gap;
    seq_flags_t                 flags;
    run_sum = run_sum + {{(ssps_pkg::SUM_W - 16){value[15]}}, value};
    gap     = run_sum - {target[ssps_pkg::TARGET_W-1], target};
    if (gap == '0) hit = 1'b1;
    foreach (seen_sums[k]) begin
      if (seen_sums[k] == gap) hit = 1'b1;
    end
    // A full store drops the prefix and marks the sequence as too long.
    if (seen_sums.size() < ssps_pkg::MAX_LEN_DEF) seen_sums.push_back(run_sum);
    else spill = 1'b1;
    if (last) begin
      flags.found    = hit;
      flags.too_long = spill;
      expected_flags.push_back(flags);
      run_sum = '0;
      seen_sums.delete();
      hit   = 1'b0;
      spill = 1'b0;
    end
  endfunction

  // Compare one accepted result with the oldest prediction.
  function void check_result(logic [ssps_pkg::OUT_DW-1:0] data);
    seq_flags_t want;
    if (expected_flags.size() == 0) begin
      $display("%0t: result with no request pending: expected none, got %b", $time, data);
      errors++;
      return;
    end
    want = expected_flags.pop_front();
    if (data[0] !== want.found) begin
      $display("%0t: found mismatch: expected %0b, got %b", $time, want.found, data[0]);
      errors++;
    end
    if (data[1] !== want.too_long) begin
      $display("%0t: too_long mismatch: expected %0b, got %b", $time, want.too_long,
               data[1]);
      errors++;
    end
    if (data[ssps_pkg::OUT_DW-1:2] !== '0) begin
      $display("%0t: padding mismatch: expected 0, got %b", $time,
               data[ssps_pkg::OUT_DW-1:2]);
      errors++;
    end
  endfunction

endclass

module tb;

  localparam int MAX_LEN = ssps_pkg::MAX_LEN_DEF;
  // The slowest request scans MAX_LEN prefixes; the longest receiver hold-off is
  // HOLD_CYCLES, and a target write waits for the block to go quiet. The limit is
  // many times the worst of these.
  localparam int STALL_LIMIT = 20000;
  localparam int HOLD_CYCLES = 400;

  logic                          clk = 1'b0;
  logic                          rst = 1'b1;
  logic                          cfg_we = 1'b0;
  logic [ssps_pkg::TARGET_W-1:0] cfg_wdata = '0;
  logic                          s_tvalid = 1'b0;
  logic                          s_tready;
  logic [ssps_pkg::IN_DW-1:0]    s_tdata = '0;   // [15:0] value
  logic                          s_tlast = 1'b0;
  logic                          m_tvalid;
  logic                          m_tready = 1'b0;
  logic [ssps_pkg::OUT_DW-1:0]   m_tdata;        // [0] found, [1] too_long, rest zero

  prefix_match_board board = new();

  int send_gap_pct  = 0;
  int recv_gap_pct  = 0;
  int hold_requests = 0;
  int holds_taken   = 0;
  int hold_left     = 0;
  int quiet_cycles  = 0;

  subarray_sum_prefix_set_detect_top DUT (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tlast   (s_tlast),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

  always #6 clk = ~clk;

  // Watchdog: ends the run when no request moves on either side for too long.
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("status: fail");
        $finish;
      end
    end
  end

  // Result side: checks each accepted result, then picks the next ready value.
  // A hold-off request keeps ready low for HOLD_CYCLES counted here.
  initial begin
    forever begin
      @(posedge clk);
      if (m_tvalid && m_tready) board.check_result(m_tdata);
      if (holds_taken != hold_requests) begin
        holds_taken = hold_requests;
        hold_left   = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= ($urandom_range(99) >= recv_gap_pct);
      end
    end
  end

  // Offer one request, with random idle cycles ahead of it, until accepted.
  task automatic push_item(input int value, input bit last);
    while ($urandom_range(99) < send_gap_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= 16'(value);
    s_tlast  <= last;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    board.note_request(16'(value), last);
  endtask

  // Write the target once every result is in and the block has gone quiet.
  task automatic write_target(input logic [ssps_pkg::TARGET_W-1:0] t);
    s_tvalid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
    repeat (MAX_LEN + 8) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= t;
    @(posedge clk);
    cfg_we <= 1'b0;
    board.set_target(t);
  endtask

  // Targets: mostly small so matches are common, with extremes mixed in.
  function automatic logic [ssps_pkg::TARGET_W-1:0] pick_target();
    case ($urandom_range(9))
      0:       return {1'b1, {(ssps_pkg::TARGET_W - 1){1'b0}}};
      1:       return {1'b0, {(ssps_pkg::TARGET_W - 1){1'b1}}};
      2:       return '0;
      3:       return ssps_pkg::TARGET_W'($urandom);
      default: return ssps_pkg::TARGET_W'(int'($urandom_range(40)) - 20);
    endcase
  endfunction

  // Values: small ones make sums hit small targets; full-range and extreme
  // values exercise every bit and the sign.
  function automatic int draw_value();
    int r;
    r = $urandom_range(99);
    if (r < 55) return int'($urandom_range(12)) - 6;
    if (r < 85) return int'($urandom_range(65535)) - 32768;
    case ($urandom_range(4))
      0:       return -32768;
      1:       return 32767;
      2:       return -1;
      3:       return 1;
      default: return 0;
    endcase
  endfunction

  function automatic int draw_length();
    int r;
    r = $urandom_range(99);
    if (r < 80) return $urandom_range(8, 1);
    if (r < 95) return $urandom_range(40, 9);
    return $urandom_range(120, 41);
  endfunction

  // Random sequences in chunks, each chunk under a freshly written target.
  task automatic random_phase(input int n_items, input bit squeeze);
    int sent;
    int chunk_end;
    int len;
    sent = 0;
    while (sent < n_items) begin
      write_target(pick_target());
      if (squeeze && sent == 0) hold_requests <= hold_requests + 1;
      chunk_end = sent + 45;
      while (sent < chunk_end && sent < n_items) begin
        len = draw_length();
        for (int k = 0; k < len; k++) push_item(draw_value(), k == len - 1);
        sent += len;
      end
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Sender idles lightly, receiver heavily.
    send_gap_pct = 21;
    recv_gap_pct = 84;

    // Target at its reset value of zero: a lone zero, a miss, extremes that
    // cancel, and a zero-sum run followed by more items after the match.
    push_item(0, 1);
    push_item(5, 1);
    push_item(32767, 0);
    push_item(-32768, 0);
    push_item(1, 1);
    push_item(-1, 0);
    push_item(0, 0);
    push_item(7, 1);

    // Extreme targets that short sequences cannot reach.
    write_target({1'b0, {(ssps_pkg::TARGET_W - 1){1'b1}}});
    push_item(32767, 0);
    push_item(32767, 1);
    write_target({1'b1, {(ssps_pkg::TARGET_W - 1){1'b0}}});
    push_item(-32768, 1);

    // Match against a stored prefix, then a match on the whole prefix.
    write_target(ssps_pkg::TARGET_W'(10));
    push_item(2, 0);
    push_item(4, 0);
    push_item(6, 1);
    push_item(20, 0);
    push_item(-10, 1);

    random_phase(180, 1'b0);

    // Sender idles heavily, receiver lightly.
    send_gap_pct = 84;
    recv_gap_pct = 21;
    random_phase(180, 1'b0);

    // No idling; the receiver holds off at the start so the block backs up.
    send_gap_pct = 0;
    recv_gap_pct = 0;
    random_phase(190, 1'b1);

    s_tvalid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
    repeat (MAX_LEN + 8) @(posedge clk);

    if (board.fail_count() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
